// File: src/median_filter_3x3_core_macros.svh
// ----------------------------------------------------------------------------
// median_filter_3x3_core_macros : assertion macros
// Implication checks clocked on clk with rst_n low disabling them.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_FILTER_3X3_CORE_MACROS_SVH
`define MEDIAN_FILTER_3X3_CORE_MACROS_SVH

`ifndef SYNTH

`define MF3_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define MF3_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MF3_ASSERT_IMP(lbl, ante, cons, msg)

`define MF3_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// File: src/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg
// Types, register codes and compare helpers of the 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

  localparam int PIX_W       = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int WIDTH_REG_W = 12;
  localparam int HEIGHT_W    = 16;
  localparam int OUT_COL_W   = 11;

  localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_W-1:0]    HEIGHT_RESET = 16'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0]     median;
    logic [OUT_COL_W-1:0] center_col;
    logic [HEIGHT_W-1:0]  center_row;
    logic                 frame_end;
  } result_t;

  // one window column, sorted low to high
  typedef struct packed {
    logic [PIX_W-1:0] hi;
    logic [PIX_W-1:0] md;
    logic [PIX_W-1:0] lo;
  } col_t;

  function automatic logic [PIX_W-1:0] max2(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [PIX_W-1:0] max3(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    return max2(max2(a, b), c);
  endfunction

  function automatic logic [PIX_W-1:0] min3(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    return min2(min2(a, b), c);
  endfunction

  function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic col_t sort3(input logic [PIX_W-1:0] a,
                                 input logic [PIX_W-1:0] b,
                                 input logic [PIX_W-1:0] c);
    col_t s;
    s.lo = min3(a, b, c);
    s.hi = max3(a, b, c);
    s.md = med3(a, b, c);
    return s;
  endfunction

endpackage

// File: src/mf3_ram.sv
// ----------------------------------------------------------------------------
// mf3_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mf3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/mf3_col_cell.sv
// ----------------------------------------------------------------------------
// mf3_col_cell
// One window column: sorts the column it takes and hands it on when enabled.
// ----------------------------------------------------------------------------
module mf3_col_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  mf3_pkg::col_t col_in,
  output mf3_pkg::col_t col_out
);

  import mf3_pkg::*;

  col_t col_r;
  col_t col_nxt;

  assign col_nxt = sort3(col_in.hi, col_in.md, col_in.lo);
  assign col_out = col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (en) begin
      col_r <= col_nxt;
    end
  end

endmodule

// File: src/median_filter_3x3_core.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_core
// 3x3 median filter over a raster-order 8-bit pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter on the in_ channel (in_valid, in_stall, in_data); frame_start
// forces the pixel to column 0, row 0. One result per interior pixel leaves
// on the out_ channel (out_valid, out_stall, out_data) in raster order; border
// pixels give nothing. image_width and image_height are set through the cfg_
// port (cfg_index 0 and 1), which is always ready.
// Throughput is one pixel per clock while in_stall is low, set by the line
// store (separate write and read ports) read at the current column and the
// fixed compare network behind the window. A result passes these stages:
// line store read, window column shift, row of min/median/max, final median.
// Reset restores 640x480, clears the position and the window; the line store
// is not cleared and needs no sweep.
// When the receiver stalls, the output register holds and stages fill up;
// bubbles from border pixels are absorbed, and in_stall rises only once every
// stage holds data.
// ----------------------------------------------------------------------------
`include "median_filter_3x3_core_macros.svh"

module median_filter_3x3_core #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mf3_pkg::pix_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mf3_pkg::result_t                    out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mf3_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mf3_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import mf3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (WW > WIDTH_REG_W) ? WW : WIDTH_REG_W;
  localparam int PW = 2 * PIX_W;

  // configuration
  logic [WIDTH_REG_W-1:0] width_r, width_nxt;
  logic [HEIGHT_W-1:0]    height_r, height_nxt;
  logic [EW-1:0]          width_ext;
  logic [EW-1:0]          eff_w;
  logic [HEIGHT_W-1:0]    eff_h;

  assign cfg_ready = 1'b1;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  width_nxt  = cfg_data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: height_nxt = cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  assign width_ext = EW'(width_r);

  always_comb begin
    if (width_ext > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else if (width_ext == '0) begin
      eff_w = EW'(1);
    end else begin
      eff_w = width_ext;
    end
    eff_h = (height_r == '0) ? HEIGHT_W'(1) : height_r;
  end

  // stage handshake
  logic s1_v_r, s2_v_r, s3_v_r, out_valid_r;
  logic s1_ready, s2_ready, s3_ready, s4_ready;
  logic in_accept;

  assign s4_ready  = !out_valid_r || !out_stall;
  assign s3_ready  = !s3_v_r || s4_ready;
  assign s2_ready  = !s2_v_r || s3_ready;
  assign s1_ready  = !s1_v_r || s2_ready;
  assign in_stall  = !s1_ready;
  assign in_accept = in_valid && s1_ready;

  // position of the incoming pixel
  logic [CW-1:0]       col_r, col_nxt;
  logic [HEIGHT_W-1:0] row_r, row_nxt;
  logic [CW-1:0]       c0, acc_col;
  logic [HEIGHT_W-1:0] r0, acc_row;
  logic [HEIGHT_W:0]   r1, row_inc;
  logic [EW-1:0]       col_inc;
  logic                acc_emit, acc_fe;

  always_comb begin
    c0 = in_data.frame_start ? '0 : col_r;
    r0 = in_data.frame_start ? '0 : row_r;
    if (EW'(c0) >= eff_w) begin
      acc_col = '0;
      r1      = {1'b0, r0} + (HEIGHT_W+1)'(1);
    end else begin
      acc_col = c0;
      r1      = {1'b0, r0};
    end
    acc_row = (r1 >= {1'b0, eff_h}) ? '0 : r1[HEIGHT_W-1:0];

    col_inc = EW'(acc_col) + EW'(1);
    row_inc = {1'b0, acc_row} + (HEIGHT_W+1)'(1);
    if (col_inc >= eff_w) begin
      col_nxt = '0;
      row_nxt = (row_inc >= {1'b0, eff_h}) ? '0 : row_inc[HEIGHT_W-1:0];
    end else begin
      col_nxt = col_inc[CW-1:0];
      row_nxt = acc_row;
    end

    acc_emit = (acc_col >= CW'(2)) && (acc_row >= HEIGHT_W'(2));
    acc_fe   = (EW'(acc_col) == eff_w - EW'(1)) && (acc_row == eff_h - HEIGHT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage 1: line store read in flight
  logic [PIX_W-1:0]     s1_px_r;
  logic [CW-1:0]        s1_col_r;
  logic                 s1_emit_r;
  logic [OUT_COL_W-1:0] s1_ccol_r;
  logic [HEIGHT_W-1:0]  s1_crow_r;
  logic                 s1_fe_r;
  logic                 fwd_r, fwd_nxt;
  logic [PW-1:0]        fwd_pair_r;
  logic [PW-1:0]        ram_rdata;
  logic [PW-1:0]        pair;
  logic [PW-1:0]        wr_pair;
  logic                 s1_adv;

  assign s1_adv  = s1_v_r && s2_ready;
  assign pair    = fwd_r ? fwd_pair_r : ram_rdata;
  assign wr_pair = {pair[PIX_W-1:0], s1_px_r};
  assign fwd_nxt = s1_v_r && (s1_col_r == acc_col);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      fwd_r  <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= in_accept;
      end
      if (in_accept) begin
        fwd_r <= fwd_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_px_r    <= in_data.pixel;
      s1_col_r   <= acc_col;
      s1_emit_r  <= acc_emit;
      s1_ccol_r  <= OUT_COL_W'(acc_col - CW'(1));
      s1_crow_r  <= acc_row - HEIGHT_W'(1);
      s1_fe_r    <= acc_fe;
      fwd_pair_r <= wr_pair;
    end
  end

  // entry: {row before previous, previous row} at each column
  mf3_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (wr_pair),
    .re    (in_accept),
    .raddr (acc_col),
    .rdata (ram_rdata)
  );

  // stage 2: window of three sorted columns
  col_t new_col, win0, win1, win2;

  assign new_col.hi = pair[PW-1:PIX_W];
  assign new_col.md = pair[PIX_W-1:0];
  assign new_col.lo = s1_px_r;

  mf3_col_cell u_cell0 (
    .clk (clk), .rst_n (rst_n), .en (s1_adv), .col_in (new_col), .col_out (win0)
  );
  mf3_col_cell u_cell1 (
    .clk (clk), .rst_n (rst_n), .en (s1_adv), .col_in (win0), .col_out (win1)
  );
  mf3_col_cell u_cell2 (
    .clk (clk), .rst_n (rst_n), .en (s1_adv), .col_in (win1), .col_out (win2)
  );

  logic [OUT_COL_W-1:0] s2_ccol_r;
  logic [HEIGHT_W-1:0]  s2_crow_r;
  logic                 s2_fe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_ready) begin
      s2_v_r <= s1_v_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_ccol_r <= s1_ccol_r;
      s2_crow_r <= s1_crow_r;
      s2_fe_r   <= s1_fe_r;
    end
  end

  // stage 3: max of lows, median of middles, min of highs
  logic [PIX_W-1:0]     lo_max_r, md_med_r, hi_min_r;
  logic [OUT_COL_W-1:0] s3_ccol_r;
  logic [HEIGHT_W-1:0]  s3_crow_r;
  logic                 s3_fe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_ready) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r && s3_ready) begin
      lo_max_r  <= max3(win0.lo, win1.lo, win2.lo);
      md_med_r  <= med3(win0.md, win1.md, win2.md);
      hi_min_r  <= min3(win0.hi, win1.hi, win2.hi);
      s3_ccol_r <= s2_ccol_r;
      s3_crow_r <= s2_crow_r;
      s3_fe_r   <= s2_fe_r;
    end
  end

  // output register
  result_t out_data_r, out_data_nxt;

  always_comb begin
    out_data_nxt.median     = med3(lo_max_r, md_med_r, hi_min_r);
    out_data_nxt.center_col = s3_ccol_r;
    out_data_nxt.center_row = s3_crow_r;
    out_data_nxt.frame_end  = s3_fe_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s4_ready) begin
      out_valid_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_v_r && s4_ready) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `MF3_ASSERT_NXT(a_fs_col, in_accept && in_data.frame_start && (eff_w > EW'(1)), col_r == CW'(1), "frame start did not restart the column")
  `MF3_ASSERT_NXT(a_col_range, in_accept, EW'(col_r) < $past(eff_w), "column count beyond image width")
  `MF3_ASSERT_IMP(a_out_src, $rose(out_valid_r), $past(s3_v_r), "result without a stage 3 entry")
  `MF3_ASSERT_NXT(a_s2_hold, s2_v_r && !s3_ready, s2_v_r, "window entry lost while blocked")

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb : median_filter_3x3_core regression
// Streams directed and random frames through the 3x3 median filter. A
// scoreboard class tracks position, line rows and window, predicts every
// interior median and compares each result transfer field by field. The
// input idles and the output stalls at random. Frame sizes change between
// frames and widths shrink inside frames. Once, the output is held off long
// enough to back up the input.
// ----------------------------------------------------------------------------
module tb;
  import mf3_pkg::*;

  localparam int MAX_W        = 2048;
  localparam int CLK_HALF     = 4;
  localparam int SETTLE       = 12;
  localparam int QUIET_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PIXEL_TARGET = 1700;

  class median_tracker;
    logic [WIDTH_REG_W-1:0] width_reg;
    logic [HEIGHT_W-1:0]    height_reg;
    logic [PIX_W-1:0]       row_above[MAX_W];
    logic [PIX_W-1:0]       row_above2[MAX_W];
    logic [PIX_W-1:0]       win[9];
    int unsigned            col_pos;
    int unsigned            row_pos;
    result_t                pending_medians[$];
    int                     mismatches;
    int                     checked;

    function new();
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      foreach (win[i]) win[i] = '0;
      foreach (row_above[i]) begin
        row_above[i]  = '0;
        row_above2[i] = '0;
      end
      col_pos    = 0;
      row_pos    = 0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function int unsigned eff_width();
      if (width_reg > MAX_W) return MAX_W;
      if (width_reg == '0) return 1;
      return int'(width_reg);
    endfunction

    function int unsigned eff_height();
      if (height_reg == '0) return 1;
      return int'(height_reg);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_IMAGE_WIDTH:  width_reg  = data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: height_reg = data[HEIGHT_W-1:0];
        default: ;
      endcase
    endfunction

    // note an accepted pixel and queue the median it completes, if any
    function void take_pixel(pix_in_t item);
      int unsigned      w;
      int unsigned      h;
      int unsigned      col;
      int unsigned      row;
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] key;
      logic [PIX_W-1:0] s[9];
      int               j;
      result_t          r;
      w = eff_width();
      h = eff_height();
      if (item.frame_start) begin
        col_pos = 0;
        row_pos = 0;
      end
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      col = col_pos;
      row = row_pos;
      top = row_above2[col];
      mid = row_above[col];
      row_above2[col] = mid;
      row_above[col]  = item.pixel;
      for (int k = 0; k < 3; k++) begin
        win[3*k]   = win[3*k+1];
        win[3*k+1] = win[3*k+2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = item.pixel;
      if (col >= 2 && row >= 2) begin
        s = win;
        for (int i = 1; i < 9; i++) begin
          key = s[i];
          j = i - 1;
          while (j >= 0 && s[j] > key) begin
            s[j+1] = s[j];
            j--;
          end
          s[j+1] = key;
        end
        r.median     = s[4];
        r.center_col = OUT_COL_W'(col - 1);
        r.center_row = HEIGHT_W'(row - 1);
        r.frame_end  = (col == w - 1 && row == h - 1);
        pending_medians = {pending_medians, r};
      end
      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) row = 0;
      end
      col_pos = col;
      row_pos = row;
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_medians.size() == 0) begin
        $error("unexpected result transfer: col %0d row %0d median %0d",
               got.center_col, got.center_row, got.median);
        mismatches++;
        return;
      end
      want = pending_medians.pop_front();
      checked++;
      if (got.median !== want.median) begin
        $error("median: expected %0d, got %0d", want.median, got.median);
        mismatches++;
      end
      if (got.center_col !== want.center_col) begin
        $error("center_col: expected %0d, got %0d", want.center_col, got.center_col);
        mismatches++;
      end
      if (got.center_row !== want.center_row) begin
        $error("center_row: expected %0d, got %0d", want.center_row, got.center_row);
        mismatches++;
      end
      if (got.frame_end !== want.frame_end) begin
        $error("frame_end: expected %0d, got %0d", want.frame_end, got.frame_end);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  pix_in_t               in_data;
  logic                  out_valid;
  logic                  out_stall;
  result_t               out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic          idle_on;
  logic          hold_req;
  int            pixels_in  = 0;
  int            reg_writes = 0;
  int            quiet      = 0;
  median_tracker tracker;

  median_filter_3x3_core #(
    .MAX_WIDTH (MAX_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // transfer monitor and watchdog
  always @(posedge clk) begin : monitor
    logic moved;
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        tracker.set_reg(cfg_index, cfg_data);
        reg_writes++;
        moved = 1'b1;
      end
      if (in_valid && !in_stall) begin
        tracker.take_pixel(in_data);
        pixels_in++;
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        tracker.check_result(out_data);
        moved = 1'b1;
      end
      if (moved) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: %0d cycles without a transfer", quiet);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int   r;
    logic held;
    out_stall = 1'b0;
    held      = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!idle_on) begin
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_stall <= 1'b0;
        end else if (r < 96) begin
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b1;
          repeat ($urandom_range(5, 40)) @(negedge clk);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return 8'($urandom_range(120, 135));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // all driving tasks start and end just after a falling edge
  task automatic push_pixel(input logic [PIX_W-1:0] px, input logic fs);
    pix_in_t item;
    int      gap;
    item.pixel       = px;
    item.frame_start = fs;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_frame(input int unsigned count, input logic first_fs);
    logic fs;
    for (int unsigned k = 0; k < count; k++) begin
      fs = (k == 0) ? first_fs : ($urandom_range(0, 399) == 0);
      push_pixel(pick_pixel(), fs);
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  // stop offering, let every expected median out, then let the pipe empty
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending_medians.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    int          r;
    int unsigned w;
    int unsigned h;
    int unsigned frames;
    int unsigned area;
    int unsigned cut;
    logic        fs_first;
    tracker   = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_data  = '0;
    idle_on   = 1'b0;
    hold_req  = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset size, then smallest frame with alternating extremes
    push_pixel(8'h00, 1'b0);
    push_pixel(8'hff, 1'b0);
    drain();
    configure(16'd3, 16'd3);
    for (int k = 0; k < 9; k++)
      push_pixel((k == 4) ? 8'h80 : ((k % 2 == 0) ? 8'hff : 8'h00), k == 0);
    // next frame starts by wrapping, no frame_start
    for (int k = 0; k < 9; k++)
      push_pixel((k < 5) ? 8'hff : 8'h00, 1'b0);
    drain();
    // zero sizes count as one, never a result
    configure(16'd0, 16'd0);
    for (int k = 0; k < 3; k++)
      push_pixel(8'h5a, k == 0);

    // output held off while the input keeps coming
    drain();
    configure(16'd6, 16'd12);
    hold_req = 1'b1;
    send_frame(72, 1'b1);

    // saturated width and tallest frame, then shrink inside the frame
    drain();
    idle_on = 1'b1;
    configure(16'd4095, 16'd65535);
    send_frame(300, 1'b1);
    drain();
    configure(16'd5, 16'd65535);
    send_frame(60, 1'b0);

    while (pixels_in < PIXEL_TARGET) begin
      drain();
      idle_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 8) w = $urandom_range(0, 2);
      else if (r < 12) w = $urandom_range(65, 160);
      else if (r < 22) w = $urandom_range(13, 64);
      else w = $urandom_range(3, 12);
      r = $urandom_range(0, 99);
      if (r < 8) h = $urandom_range(0, 2);
      else if (r < 12) h = $urandom_range(9, 40);
      else h = $urandom_range(3, 8);
      if (w > 64) h = 3;
      else if (w > 12 && h > 8) h = 8;
      configure(16'(w), 16'(h));
      frames = $urandom_range(1, 3);
      for (int unsigned f = 0; f < frames; f++) begin
        if (pixels_in >= PIXEL_TARGET) break;
        area = tracker.eff_width() * tracker.eff_height();
        fs_first = (f == 0) ? 1'b1 : 1'($urandom_range(0, 1));
        if ($urandom_range(0, 4) == 0) begin
          // resize part way; width only shrinks so every row read was written
          cut = $urandom_range(1, area);
          send_frame(cut, fs_first);
          drain();
          w = $urandom_range(0, tracker.eff_width());
          h = $urandom_range(0, 12);
          configure(16'(w), 16'(h));
          send_frame(area - cut + $urandom_range(0, 10), 1'b0);
        end else begin
          send_frame(area, fs_first);
        end
      end
    end

    drain();
    $display("run covered %0d pixels, %0d medians compared, %0d register writes",
             pixels_in, tracker.checked, reg_writes);
    $display("sizes degenerate to saturated, resizes inside frames, %0d-cycle output hold",
             HOLD_CYCLES);
    if (tracker.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
